>>> sv/ppg_heart_rate_detector_assert.svh
// ----------------------------------------------------------------------------
// ppg heart rate detector assertion macros
// shared property forms used by the detector rtl
// ----------------------------------------------------------------------------
`ifndef PPG_HEART_RATE_DETECTOR_ASSERT_SVH
`define PPG_HEART_RATE_DETECTOR_ASSERT_SVH

// expression must never hold outside reset
`define PHD_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("phd: forbidden condition seen");

// consequence holds in the same cycle as the antecedent
`define PHD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phd: same-cycle implication failed");

// consequence holds in the cycle after the antecedent
`define PHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phd: next-cycle implication failed");

`endif

>>> sv/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// types, constants and helpers of the ppg heart rate detector
// ----------------------------------------------------------------------------
package phd_pkg;

  // level and intermediate widths
  localparam int unsigned LVL_W = 48;
  localparam int unsigned XW    = 51;
  localparam int unsigned SUM_W = 52;
  localparam int unsigned DIV_NW = 40;
  localparam int unsigned DIV_DW = 32;

  // configuration register indexes
  localparam logic [2:0] CFG_DC_ALPHA     = 3'd0;
  localparam logic [2:0] CFG_SMOOTH_ALPHA = 3'd1;
  localparam logic [2:0] CFG_THR_FRAC     = 3'd2;
  localparam logic [2:0] CFG_MIN_GAP      = 3'd3;
  localparam logic [2:0] CFG_WIN_LEN      = 3'd4;
  localparam logic [2:0] CFG_SHORTEST     = 3'd5;
  localparam logic [2:0] CFG_LONGEST      = 3'd6;

  // fixed constants
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] DECAY_Q16   = 17'd65470;
  localparam logic [16:0] BPM_NUMER   = 17'd120000;
  localparam logic [9:0]  BPM_MAX     = 10'd1023;
  localparam logic [6:0]  CONF_MAX    = 7'd100;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOSS,
    ST_DC_MUL,
    ST_DC_WAIT,
    ST_SM_MUL,
    ST_SM_WAIT,
    ST_ENV,
    ST_ENV_WAIT,
    ST_PEAK,
    ST_THR_WAIT,
    ST_OUTLIER,
    ST_PUSH,
    ST_WRAP,
    ST_RESULT,
    ST_MED_RDI,
    ST_MED_LDI,
    ST_MED_CMP,
    ST_BPM_DIV,
    ST_BPM_WAIT,
    ST_CONF,
    ST_CONF_WAIT,
    ST_OUT
  } state_e;

  // request to the shared weight multiplier
  typedef struct packed {
    logic                 start;
    logic signed [XW-1:0] x;
    logic [16:0]          w;
  } mul_req_t;

  // request to the serial divider
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  // clamp to the signed 48-bit range
  function automatic logic signed [LVL_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(LVL_W-1){1'b1}}}));
    lo = -(SUM_W'(signed'({1'b0, {(LVL_W-1){1'b1}}}))) - SUM_W'(1);
    if (x > hi) begin
      sat48 = {1'b0, {(LVL_W-1){1'b1}}};
    end else if (x < lo) begin
      sat48 = {1'b1, {(LVL_W-1){1'b0}}};
    end else begin
      sat48 = x[LVL_W-1:0];
    end
  endfunction

  // weights above one saturate to one
  function automatic logic [16:0] weight(input logic [16:0] w);
    weight = w[16] ? ONE_Q16 : w;
  endfunction

endpackage

>>> sv/ppg_heart_rate_detector.sv
// ----------------------------------------------------------------------------
// ppg_heart_rate_detector
// heart rate, confidence and beat flag from a stream of ppg samples
// ----------------------------------------------------------------------------
// One item (sample and ms timestamp) is taken at a time; in_ready_o is low
// until its result item has been taken. An item passes through the
// sequencing states, 2 to 4 multiplier passes, up to two divisions, up to
// two median searches over the n intervals held and, when it accepts a
// beat, the store of its interval. The 17x18 weight multiplier, the
// bit-serial divider and the interval memory with one read and one write
// port set how long an item takes. No clearing pass is needed after reset.
module ppg_heart_rate_detector
  import phd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [31:0]            time_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [9:0]             heart_rate_bpm_o,
  output logic [6:0]             confidence_pct_o,
  output logic [31:0]            time_echo_ms_o,
  output logic                   beat_flag_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [16:0]            cfg_data_i
);

`include "ppg_heart_rate_detector_assert.svh"

  localparam int unsigned IW = $clog2(WINDOW_DEPTH);
  localparam int unsigned LW = $clog2(WINDOW_DEPTH + 1);

  // configuration registers
  logic [16:0] dc_alpha_q, smooth_alpha_q, thr_frac_q;
  logic [11:0] min_gap_q, longest_q;
  logic [3:0]  win_len_q;
  logic [10:0] shortest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_alpha_q     <= 17'd655;
      smooth_alpha_q <= 17'd13107;
      thr_frac_q     <= 17'd26214;
      min_gap_q      <= 12'd250;
      win_len_q      <= 4'd8;
      shortest_q     <= 11'd300;
      longest_q      <= 12'd2000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DC_ALPHA:     dc_alpha_q     <= cfg_data_i;
        CFG_SMOOTH_ALPHA: smooth_alpha_q <= cfg_data_i;
        CFG_THR_FRAC:     thr_frac_q     <= cfg_data_i;
        CFG_MIN_GAP:      min_gap_q      <= cfg_data_i[11:0];
        CFG_WIN_LEN:      win_len_q      <= cfg_data_i[3:0];
        CFG_SHORTEST:     shortest_q     <= cfg_data_i[10:0];
        CFG_LONGEST:      longest_q      <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // effective window length, clamped to 3..WINDOW_DEPTH
  logic [7:0]    wl8;
  logic [LW-1:0] len;
  assign wl8 = {4'b0, win_len_q};
  always_comb begin
    if (wl8 < 8'd3) begin
      len = LW'(3);
    end else if (wl8 > 8'(WINDOW_DEPTH)) begin
      len = LW'(WINDOW_DEPTH);
    end else begin
      len = LW'(wl8);
    end
  end

  // state
  state_e state_q, state_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [31:0] t_q, t_d;
  logic signed [LVL_W-1:0] dc_q, dc_d, sm_q, sm_d, env_q, env_d;
  logic signed [LVL_W-1:0] prev_q, prev_d, cand_q, cand_d;
  logic rising_q, rising_d, await_q, await_d;
  logic [31:0] last_q, last_d, iv_q, iv_d;
  logic [IW-1:0] widx_q, widx_d;
  logic [LW:0]   wrap_q, wrap_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [1:0]    run_q, run_d;
  logic [31:0]   total_q, total_d, valid_q, valid_d;
  logic [9:0]    bpm_q, bpm_d;
  logic [6:0]    conf_q, conf_d;
  logic          beat_q, beat_d;
  logic          med_out_q, med_out_d;
  logic [15:0]   med_q, med_d, mv_q, mv_d;
  logic [IW-1:0] mi_q, mi_d, mj_q, mj_d;
  logic [LW-1:0] rank_q, rank_d;

  // interval memory
  logic [15:0]   win_mem [WINDOW_DEPTH];
  logic [15:0]   rd_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[widx_q] <= iv_q[15:0];
    end
    rd_q <= win_mem[rd_addr];
  end

  // shared units
  mul_req_t mul_req;
  logic     mul_done;
  logic signed [XW-1:0] mul_res;
  div_req_t div_req;
  logic     div_done;
  logic [DIV_NW-1:0] div_quo;

  phd_mulw u_mulw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  phd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // datapath helpers
  logic signed [XW-1:0]    raw;
  logic signed [LVL_W-1:0] sig;
  logic signed [XW-1:0]    thr;
  logic [31:0]   iv_now;
  logic          hit;
  logic [LW-1:0] rank_new;
  logic [15:0]   dev;
  logic [19:0]   dev10, med3;
  logic [39:0]   conf_num;

  assign raw = signed'({{(XW - SAMPLE_BITS - 16){1'b0}}, sample_q, 16'b0});
  assign sig = sat48(SUM_W'(raw) - SUM_W'(dc_q));
  assign thr = (mul_res < XW'(signed'({1'b0, ONE_Q16}))) ?
               XW'(signed'({1'b0, ONE_Q16})) : mul_res;
  assign iv_now = t_q - last_q;
  assign hit = (rd_q < mv_q) || ((rd_q == mv_q) && (mj_q < mi_q));
  assign rank_new = rank_q + LW'(hit);
  assign dev = (iv_q[15:0] > med_q) ? (iv_q[15:0] - med_q) : (med_q - iv_q[15:0]);
  assign dev10 = ({4'b0, dev} << 3) + ({4'b0, dev} << 1);
  assign med3  = {4'b0, med_q} + ({4'b0, med_q} << 1);
  assign conf_num = ({8'b0, valid_q} << 6) + ({8'b0, valid_q} << 5) +
                    ({8'b0, valid_q} << 2);

  // sequencer
  always_comb begin
    state_d   = state_q;
    sample_d  = sample_q;
    t_d       = t_q;
    dc_d      = dc_q;
    sm_d      = sm_q;
    env_d     = env_q;
    prev_d    = prev_q;
    cand_d    = cand_q;
    rising_d  = rising_q;
    await_d   = await_q;
    last_d    = last_q;
    iv_d      = iv_q;
    widx_d    = widx_q;
    wrap_d    = wrap_q;
    fill_d    = fill_q;
    run_d     = run_q;
    total_d   = total_q;
    valid_d   = valid_q;
    bpm_d     = bpm_q;
    conf_d    = conf_q;
    beat_d    = beat_q;
    med_out_d = med_out_q;
    med_d     = med_q;
    mv_d      = mv_q;
    mi_d      = mi_q;
    mj_d      = mj_q;
    rank_d    = rank_q;
    rd_addr   = mi_q;
    wr_en     = 1'b0;
    mul_req   = '0;
    div_req   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sample_d = sample_i;
          t_d      = time_ms_i;
          bpm_d    = '0;
          conf_d   = '0;
          beat_d   = 1'b0;
          state_d  = ST_LOSS;
        end
      end
      // signal loss clears the beat history
      ST_LOSS: begin
        if (!await_q && (iv_now > {19'b0, longest_q, 1'b0})) begin
          widx_d   = '0;
          fill_d   = '0;
          run_d    = '0;
          total_d  = '0;
          valid_d  = '0;
          await_d  = 1'b1;
          last_d   = '0;
          rising_d = 1'b0;
          cand_d   = '0;
        end
        state_d = ST_DC_MUL;
      end
      ST_DC_MUL: begin
        mul_req.start = 1'b1;
        mul_req.x     = raw - XW'(dc_q);
        mul_req.w     = weight(dc_alpha_q);
        state_d       = ST_DC_WAIT;
      end
      ST_DC_WAIT: begin
        if (mul_done) begin
          dc_d    = sat48(SUM_W'(dc_q) + SUM_W'(mul_res));
          state_d = ST_SM_MUL;
        end
      end
      ST_SM_MUL: begin
        mul_req.start = 1'b1;
        mul_req.x     = XW'(sig) - XW'(sm_q);
        mul_req.w     = weight(smooth_alpha_q);
        state_d       = ST_SM_WAIT;
      end
      ST_SM_WAIT: begin
        if (mul_done) begin
          sm_d    = sat48(SUM_W'(sm_q) + SUM_W'(mul_res));
          state_d = ST_ENV;
        end
      end
      // envelope follows upward, else decays
      ST_ENV: begin
        if (sm_q > env_q) begin
          env_d   = sm_q;
          state_d = ST_PEAK;
        end else begin
          mul_req.start = 1'b1;
          mul_req.x     = XW'(env_q);
          mul_req.w     = DECAY_Q16;
          state_d       = ST_ENV_WAIT;
        end
      end
      ST_ENV_WAIT: begin
        if (mul_done) begin
          env_d   = mul_res[LVL_W-1:0];
          state_d = ST_PEAK;
        end
      end
      // rise then fall marks a candidate peak
      ST_PEAK: begin
        if (sm_q > prev_q) begin
          rising_d = 1'b1;
          if (sm_q > cand_q) begin
            cand_d = sm_q;
          end
          prev_d  = sm_q;
          state_d = ST_RESULT;
        end else if (rising_q) begin
          mul_req.start = 1'b1;
          mul_req.x     = XW'(env_q);
          mul_req.w     = weight(thr_frac_q);
          state_d       = ST_THR_WAIT;
        end else begin
          prev_d  = sm_q;
          state_d = ST_RESULT;
        end
      end
      ST_THR_WAIT: begin
        if (mul_done) begin
          rising_d = 1'b0;
          cand_d   = '0;
          prev_d   = sm_q;
          total_d  = (total_q == '1) ? total_q : total_q + 32'd1;
          state_d  = ST_RESULT;
          if (XW'(cand_q) > thr) begin
            if (await_q) begin
              last_d  = t_q;
              await_d = 1'b0;
              beat_d  = 1'b1;
            end else begin
              iv_d = iv_now;
              if (iv_now >= {20'b0, min_gap_q}) begin
                last_d = t_q;
                if (iv_now >= {21'b0, shortest_q} && iv_now <= {20'b0, longest_q}) begin
                  if (fill_q >= LW'(3)) begin
                    med_out_d = 1'b0;
                    mi_d      = '0;
                    state_d   = ST_MED_RDI;
                  end else begin
                    state_d = ST_PUSH;
                  end
                end
              end
            end
          end
        end
      end
      // outlier test against the window median
      ST_OUTLIER: begin
        if (dev10 > med3) begin
          if (run_q == 2'd2) begin
            widx_d  = '0;
            fill_d  = '0;
            run_d   = '0;
            valid_d = '0;
            total_d = 32'd1;
            state_d = ST_PUSH;
          end else begin
            run_d   = run_q + 2'd1;
            state_d = ST_RESULT;
          end
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        wr_en   = 1'b1;
        if (fill_q < len) begin
          fill_d = fill_q + LW'(1);
        end
        valid_d = (valid_q == '1) ? valid_q : valid_q + 32'd1;
        run_d   = '0;
        beat_d  = 1'b1;
        wrap_d  = (LW + 1)'(widx_q) + (LW + 1)'(1);
        state_d = ST_WRAP;
      end
      // write index wraps modulo the window length
      ST_WRAP: begin
        if (wrap_q >= {1'b0, len}) begin
          wrap_d = wrap_q - {1'b0, len};
        end else begin
          widx_d  = IW'(wrap_q);
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (fill_q >= LW'(3)) begin
          med_out_d = 1'b1;
          mi_d      = '0;
          state_d   = ST_MED_RDI;
        end else begin
          bpm_d   = '0;
          state_d = ST_CONF;
        end
      end
      // median by rank: find the entry whose stable rank is n/2
      ST_MED_RDI: begin
        rd_addr = mi_q;
        state_d = ST_MED_LDI;
      end
      ST_MED_LDI: begin
        rd_addr = '0;
        mv_d    = rd_q;
        mj_d    = '0;
        rank_d  = '0;
        state_d = ST_MED_CMP;
      end
      ST_MED_CMP: begin
        rd_addr = mj_q + IW'(1);
        if (LW'(mj_q) == fill_q - LW'(1)) begin
          if (rank_new == (fill_q >> 1)) begin
            med_d = mv_q;
            if (med_out_q) begin
              if (mv_q == '0) begin
                bpm_d   = '0;
                state_d = ST_CONF;
              end else begin
                state_d = ST_BPM_DIV;
              end
            end else begin
              state_d = ST_OUTLIER;
            end
          end else begin
            mi_d    = mi_q + IW'(1);
            state_d = ST_MED_RDI;
          end
        end else begin
          mj_d   = mj_q + IW'(1);
          rank_d = rank_new;
        end
      end
      ST_BPM_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(BPM_NUMER) + DIV_NW'(med_q);
        div_req.den   = DIV_DW'({med_q, 1'b0});
        state_d       = ST_BPM_WAIT;
      end
      ST_BPM_WAIT: begin
        if (div_done) begin
          bpm_d   = (div_quo > DIV_NW'(BPM_MAX)) ? BPM_MAX : div_quo[9:0];
          state_d = ST_CONF;
        end
      end
      ST_CONF: begin
        if (total_q != '0) begin
          div_req.start = 1'b1;
          div_req.num   = conf_num;
          div_req.den   = total_q;
          state_d       = ST_CONF_WAIT;
        end else begin
          conf_d  = '0;
          state_d = ST_OUT;
        end
      end
      ST_CONF_WAIT: begin
        if (div_done) begin
          conf_d  = (div_quo > DIV_NW'(CONF_MAX)) ? CONF_MAX : div_quo[6:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dc_q     <= '0;
      sm_q     <= '0;
      env_q    <= '0;
      prev_q   <= '0;
      cand_q   <= '0;
      rising_q <= 1'b0;
      await_q  <= 1'b1;
      last_q   <= '0;
      widx_q   <= '0;
      fill_q   <= '0;
      run_q    <= '0;
      total_q  <= '0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      dc_q     <= dc_d;
      sm_q     <= sm_d;
      env_q    <= env_d;
      prev_q   <= prev_d;
      cand_q   <= cand_d;
      rising_q <= rising_d;
      await_q  <= await_d;
      last_q   <= last_d;
      widx_q   <= widx_d;
      fill_q   <= fill_d;
      run_q    <= run_d;
      total_q  <= total_d;
      valid_q  <= valid_d;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    t_q       <= t_d;
    iv_q      <= iv_d;
    wrap_q    <= wrap_d;
    bpm_q     <= bpm_d;
    conf_q    <= conf_d;
    beat_q    <= beat_d;
    med_out_q <= med_out_d;
    med_q     <= med_d;
    mv_q      <= mv_d;
    mi_q      <= mi_d;
    mj_q      <= mj_d;
    rank_q    <= rank_d;
  end

  assign heart_rate_bpm_o = bpm_q;
  assign confidence_pct_o = conf_q;
  assign time_echo_ms_o   = t_q;
  assign beat_flag_o      = beat_q;

  // checks
  `PHD_ASSERT_NEVER(a_ready_and_result, clk_i, rst_ni, in_ready_o && out_valid_o)
  `PHD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `PHD_ASSERT_NEXT(a_ready_after_result, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)
  `PHD_ASSERT_IMPL(a_mul_done_waited, clk_i, rst_ni, mul_done,
                   state_q == ST_DC_WAIT || state_q == ST_SM_WAIT ||
                   state_q == ST_ENV_WAIT || state_q == ST_THR_WAIT)
  `PHD_ASSERT_IMPL(a_div_done_waited, clk_i, rst_ni, div_done,
                   state_q == ST_BPM_WAIT || state_q == ST_CONF_WAIT)

endmodule

>>> sv/phd_mulw.sv
// ----------------------------------------------------------------------------
// phd_mulw
// signed level times Q1.16 weight, truncated toward zero, three partial products
// ----------------------------------------------------------------------------
module phd_mulw
  import phd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mul_req_t             req_i,
  output logic                 done_o,
  output logic signed [XW-1:0] res_o
);

  logic          busy_q, busy_d;
  logic [1:0]    ph_q, ph_d;
  logic          neg_q, neg_d;
  logic [XW-1:0] mag_q, mag_d;
  logic [16:0]   w_q, w_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic          done_q, done_d;
  logic signed [XW-1:0] res_q, res_d;
  logic [17:0]   op;
  logic [34:0]   prod;

  // operand chunk for the current phase
  always_comb begin
    case (ph_q)
      2'd0:    op = {2'b00, mag_q[15:0]};
      2'd1:    op = mag_q[33:16];
      default: op = {1'b0, mag_q[50:34]};
    endcase
  end

  assign prod = 35'(op) * 35'(w_q);

  // phase sequencing and accumulation
  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    w_d    = w_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      ph_d   = 2'd0;
      neg_d  = req_i.x[XW-1];
      mag_d  = req_i.x[XW-1] ? XW'(-req_i.x) : XW'(req_i.x);
      w_d    = req_i.w;
      acc_d  = '0;
    end else if (busy_q) begin
      case (ph_q)
        2'd0: begin
          acc_d = SUM_W'(prod >> 16);
          ph_d  = 2'd1;
        end
        2'd1: begin
          acc_d = acc_q + SUM_W'(prod);
          ph_d  = 2'd2;
        end
        default: begin
          acc_d  = acc_q + (SUM_W'(prod) << 18);
          busy_d = 1'b0;
          done_d = 1'b1;
          res_d  = neg_q ? -signed'(acc_d[XW-1:0]) : signed'(acc_d[XW-1:0]);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    w_q   <= w_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/phd_div.sv
// ----------------------------------------------------------------------------
// phd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module phd_div
  import phd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic              busy_q, busy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_NW-1:0] num_q, num_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic              done_q, done_d;
  logic [DIV_DW:0]   sh;
  logic              fit;

  assign sh  = {rem_q, num_q[DIV_NW-1]};
  assign fit = sh >= {1'b0, den_q};

  // shift, compare and subtract
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fit ? DIV_DW'(sh - {1'b0, den_q}) : sh[DIV_DW-1:0];
      num_d = {num_q[DIV_NW-2:0], fit};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

>>> verif/ppg_heart_rate_detector_tb.sv
// ----------------------------------------------------------------------------
// ppg_heart_rate_detector_tb
// drives ppg samples with timestamps through the detector under random
// handshake gaps and checks every result item against an in-bench predictor
// of the filters, peak logic, interval window, bpm and confidence
// ----------------------------------------------------------------------------
module ppg_heart_rate_detector_tb
  import phd_pkg::*;
();

  localparam int unsigned WDEPTH = 8;
  localparam logic signed [63:0] LIM47 = 64'sd1 <<< 47;

  typedef struct packed {
    logic [9:0]  bpm;
    logic [6:0]  conf;
    logic [31:0] t;
    logic        beat;
  } hr_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [23:0] sample_i = '0;
  logic [31:0] time_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [9:0] heart_rate_bpm_o;
  logic [6:0] confidence_pct_o;
  logic [31:0] time_echo_ms_o;
  logic beat_flag_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  ppg_heart_rate_detector dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor configuration
  logic [16:0] p_dc_alpha, p_sm_alpha, p_thr_frac;
  logic [11:0] p_min_gap, p_longest;
  logic [3:0]  p_win_len;
  logic [10:0] p_shortest;

  // predictor state
  logic signed [63:0] dc_lvl, sm_lvl, env_max, prev_sm, cand_pk;
  logic rising, awaiting;
  logic [31:0] last_pk_t;
  logic [31:0] iv_win [WDEPTH];
  int unsigned wr_idx, fill_cnt, out_run;
  logic [31:0] total_pk, valid_pk;

  hr_result_t hr_expected [$];
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_beats = 0;
  int unsigned n_bpm = 0;
  logic [31:0] t_now;

  function automatic logic signed [63:0] clamp48(input logic signed [63:0] x);
    if (x > LIM47 - 1) return LIM47 - 1;
    if (x < -LIM47) return -LIM47;
    return x;
  endfunction

  function automatic logic [16:0] sat_w(input logic [16:0] w);
    return (w > 17'd65536) ? 17'd65536 : w;
  endfunction

  // signed level times q1.16 weight, truncated toward zero
  function automatic logic signed [63:0] scale_w(input logic signed [63:0] x,
                                                 input logic [16:0] w);
    logic [63:0] m;
    logic [63:0] r;
    m = (x < 0) ? 64'(-x) : 64'(x);
    r = (m >> 16) * 64'(w) + (((m & 64'hFFFF) * 64'(w)) >> 16);
    return (x < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic int unsigned eff_len();
    int unsigned n;
    n = p_win_len;
    if (n < 3) n = 3;
    if (n > WDEPTH) n = WDEPTH;
    return n;
  endfunction

  function automatic logic [31:0] iv_median();
    logic [31:0] s [WDEPTH];
    logic [31:0] v;
    int unsigned n, i, j;
    n = (fill_cnt > WDEPTH) ? WDEPTH : fill_cnt;
    if (n == 0) return 0;
    for (i = 0; i < WDEPTH; i++) s[i] = iv_win[i];
    for (i = 1; i < n; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[n/2];
  endfunction

  task automatic clear_beats();
    for (int i = 0; i < WDEPTH; i++) iv_win[i] = '0;
    wr_idx = 0;
    fill_cnt = 0;
    out_run = 0;
    total_pk = '0;
    valid_pk = '0;
    awaiting = 1'b1;
    last_pk_t = '0;
    rising = 1'b0;
    cand_pk = '0;
  endtask

  task automatic store_interval(input logic [31:0] iv);
    int unsigned len;
    int unsigned idx;
    len = eff_len();
    idx = wr_idx % WDEPTH;
    iv_win[idx] = iv & 32'hFFFF;
    wr_idx = (idx + 1) % len;
    if (fill_cnt < len) fill_cnt++;
    if (valid_pk != 32'hFFFF_FFFF) valid_pk++;
    out_run = 0;
  endtask

  // heart rate prediction for one sample
  task automatic predict_heart_rate(input logic [23:0] smp, input logic [31:0] t);
    logic signed [63:0] raw, sig, sm, thr;
    logic [31:0] iv, med, dev;
    logic [63:0] b, c;
    hr_result_t r;
    raw = $signed({24'd0, smp, 16'd0});
    r = '0;
    r.t = t;
    if (!awaiting && (t - last_pk_t) > 32'(2 * p_longest)) clear_beats();
    dc_lvl = clamp48(dc_lvl + scale_w(raw - dc_lvl, sat_w(p_dc_alpha)));
    sig = clamp48(raw - dc_lvl);
    sm_lvl = clamp48(sm_lvl + scale_w(sig - sm_lvl, sat_w(p_sm_alpha)));
    sm = sm_lvl;
    if (sm > env_max) env_max = sm;
    else env_max = scale_w(env_max, DECAY_Q16);
    if (sm > prev_sm) begin
      rising = 1'b1;
      if (sm > cand_pk) cand_pk = sm;
    end else if (rising) begin
      thr = scale_w(env_max, sat_w(p_thr_frac));
      rising = 1'b0;
      if (total_pk != 32'hFFFF_FFFF) total_pk++;
      if (thr < 65536) thr = 65536;
      if (cand_pk > thr) begin
        if (awaiting) begin
          last_pk_t = t;
          awaiting = 1'b0;
          r.beat = 1'b1;
        end else begin
          iv = t - last_pk_t;
          if (iv >= p_min_gap) begin
            if (iv >= p_shortest && iv <= p_longest) begin
              med = iv_median();
              dev = (iv > med) ? iv - med : med - iv;
              if (fill_cnt < 3 || 64'(dev) * 10 <= 64'(med) * 3) begin
                store_interval(iv);
                r.beat = 1'b1;
              end else begin
                out_run++;
                if (out_run >= 3) begin
                  clear_beats();
                  awaiting = 1'b0;
                  total_pk = 32'd1;
                  store_interval(iv);
                  r.beat = 1'b1;
                end
              end
            end
            last_pk_t = t;
          end
        end
      end
      cand_pk = '0;
    end
    prev_sm = sm;
    if (fill_cnt >= 3) begin
      med = iv_median();
      if (med > 0) begin
        b = (64'd120000 + 64'(med)) / (64'd2 * 64'(med));
        r.bpm = (b > 1023) ? 10'd1023 : 10'(b);
      end
    end
    if (total_pk > 0) begin
      c = 64'(valid_pk) * 100 / 64'(total_pk);
      r.conf = (c > 100) ? 7'd100 : 7'(c);
    end
    hr_expected.push_back(r);
  endtask

  // send one sample item after a random gap
  task automatic send_sample(input logic [23:0] smp, input logic [31:0] t);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_heart_rate(smp, t);
    in_valid_i <= 1'b1;
    sample_i <= smp;
    time_ms_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (hr_expected.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_DC_ALPHA:     p_dc_alpha = val;
      CFG_SMOOTH_ALPHA: p_sm_alpha = val;
      CFG_THR_FRAC:     p_thr_frac = val;
      CFG_MIN_GAP:      p_min_gap = val[11:0];
      CFG_WIN_LEN:      p_win_len = val[3:0];
      CFG_SHORTEST:     p_shortest = val[10:0];
      CFG_LONGEST:      p_longest = val[11:0];
      default: ;
    endcase
  endtask

  // pulse train: one beat per period with noise, jitter, random outliers and time jumps
  task automatic send_pulses(input int unsigned n_items, input int unsigned period_ms,
                             input int unsigned step_ms, input int unsigned amp);
    int unsigned ph;
    logic [31:0] s;
    for (int unsigned k = 0; k < n_items; k++) begin
      t_now += step_ms + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : 0);
      ph = t_now % period_ms;
      s = 32'd8000000 + ((ph < period_ms / 4) ? amp * ph / (period_ms / 4) : 0)
          + $urandom_range(0, 200);
      if ($urandom_range(0, 60) == 0) s = $urandom;
      if ($urandom_range(0, 150) == 0) t_now += $urandom_range(1000, 9000);
      send_sample(s[23:0], t_now);
    end
  endtask

  // directed extremes of fields, flat input, timestamp wrap, signal loss
  task automatic test_directed();
    t_now = 32'hFFFF_FF00;
    send_sample(24'd0, 32'd0);
    send_sample(24'hFFFFFF, 32'hFFFF_FFFF);
    send_sample(24'd0, t_now);
    send_sample(24'hFFFFFF, t_now + 100);
    send_sample(24'h555555, t_now + 200);
    send_sample(24'hAAAAAA, t_now + 300);
    send_sample(24'hAAAAAA, t_now + 400);
    send_sample(24'd0, t_now + 700);
    send_sample(24'hFFFFFF, t_now + 1000);
    send_sample(24'd1, t_now + 1300);
    send_sample(24'hFFFFFF, t_now + 20000);
    send_sample(24'd0, t_now + 20400);
    t_now += 20400;
    wait_drained();
  endtask

  // default configuration with pulse trains of two rates
  task automatic test_default_rates();
    send_pulses(150, 800, 20, 400000);
    send_pulses(150, 500, 20, 1000000);
    wait_drained();
  endtask

  // extreme register settings
  task automatic test_extremes();
    write_reg(CFG_DC_ALPHA, 17'd65536);
    write_reg(CFG_SMOOTH_ALPHA, 17'd65536);
    write_reg(CFG_THR_FRAC, 17'd1);
    write_reg(CFG_MIN_GAP, 17'd100);
    write_reg(CFG_SHORTEST, 17'd100);
    write_reg(CFG_LONGEST, 17'd500);
    write_reg(CFG_WIN_LEN, 17'd3);
    send_pulses(200, 150, 10, 2000000);
    wait_drained();
    // a long silence clears history before the window grows
    send_sample(24'd0, t_now + 100000);
    t_now += 100000;
    wait_drained();
    write_reg(CFG_DC_ALPHA, 17'h1FFFF);
    write_reg(CFG_SMOOTH_ALPHA, 17'd0);
    write_reg(CFG_THR_FRAC, 17'd65536);
    write_reg(CFG_WIN_LEN, 17'd15);
    write_reg(CFG_MIN_GAP, 17'd4000);
    write_reg(CFG_SHORTEST, 17'd2000);
    write_reg(CFG_LONGEST, 17'd4000);
    send_pulses(60, 3000, 100, 3000000);
    wait_drained();
  endtask

  // random register sets, each phase after the window was emptied
  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      // a long silence clears history before the window length changes
      send_sample(24'($urandom), t_now + 100000);
      t_now += 100000;
      wait_drained();
      write_reg(CFG_DC_ALPHA, 17'($urandom_range(1, 3000)));
      write_reg(CFG_SMOOTH_ALPHA, 17'($urandom_range(3000, 65536)));
      write_reg(CFG_THR_FRAC, 17'($urandom_range(1, 50000)));
      write_reg(CFG_MIN_GAP, 17'($urandom_range(100, 400)));
      write_reg(CFG_WIN_LEN, 17'($urandom_range(0, 15)));
      write_reg(CFG_SHORTEST, 17'($urandom_range(100, 400)));
      write_reg(CFG_LONGEST, 17'($urandom_range(1200, 4000)));
      send_pulses(130, $urandom_range(400, 1100), $urandom_range(10, 40),
                  $urandom_range(50000, 3000000));
      wait_drained();
    end
  endtask

  // result checking with random output stalls
  initial begin
    hr_result_t e;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (hr_expected.size() == 0) begin
        $display("%0t: unexpected result item bpm %0d", $time, heart_rate_bpm_o);
        n_fail++;
      end else begin
        e = hr_expected.pop_front();
        n_checked++;
        if (e.beat) n_beats++;
        if (e.bpm != 0) n_bpm++;
        if (heart_rate_bpm_o !== e.bpm) begin
          $display("%0t: bpm expected %0d actual %0d", $time, e.bpm, heart_rate_bpm_o);
          n_fail++;
        end
        if (confidence_pct_o !== e.conf) begin
          $display("%0t: confidence expected %0d actual %0d", $time, e.conf,
                   confidence_pct_o);
          n_fail++;
        end
        if (time_echo_ms_o !== e.t) begin
          $display("%0t: time echo expected %0d actual %0d", $time, e.t, time_echo_ms_o);
          n_fail++;
        end
        if (beat_flag_o !== e.beat) begin
          $display("%0t: beat expected %0d actual %0d", $time, e.beat, beat_flag_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    p_dc_alpha = 17'd655;
    p_sm_alpha = 17'd13107;
    p_thr_frac = 17'd26214;
    p_min_gap = 12'd250;
    p_win_len = 4'd8;
    p_shortest = 11'd300;
    p_longest = 12'd2000;
    dc_lvl = '0;
    sm_lvl = '0;
    env_max = '0;
    prev_sm = '0;
    clear_beats();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_default_rates();
    test_extremes();
    test_random_phases();
    $display("checked %0d result items, %0d with a beat, %0d with a heart rate",
             n_checked, n_beats, n_bpm);
    if (n_fail == 0 && hr_expected.size() == 0) begin
      $display("ppg_heart_rate_detector_tb OK");
    end else begin
      $display("ppg_heart_rate_detector_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #50000000;
    $display("ppg_heart_rate_detector_tb NOT OK");
    $finish;
  end

endmodule
